>>> hw/rtl/etw_pkg.sv
package etw_pkg;

   localparam int ELASTIC_TABLE_DEPTH = 1024;
   localparam int ROM_AW = $clog2(ELASTIC_TABLE_DEPTH);
   localparam int EASE_W = 20;
   localparam int DIV_STEPS = 16;
   localparam int DIV_CW = $clog2(DIV_STEPS);

   localparam logic [16:0] PCT_ONE = 17'd65536;
   localparam logic [17:0] BACK_C3 = 18'd177051;
   localparam logic [17:0] BACK_C1 = 18'd111515;

   localparam longint Q30_ONE = 64'sd1073741824;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint LN2_Q30 = 64'sd744261118;

   typedef enum logic [1:0] {
      CMD_TICK   = 2'd0,
      CMD_START  = 2'd1,
      CMD_CANCEL = 2'd2,
      CMD_LOAD   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      REG_TARGET   = 2'd0,
      REG_DURATION = 2'd1,
      REG_DELAY    = 2'd2,
      REG_EASING   = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      EASE_LINEAR  = 2'd0,
      EASE_ELASTIC = 2'd1,
      EASE_BACK    = 2'd2,
      EASE_SPARE   = 2'd3
   } ease_mode_type;

   typedef enum logic [3:0] {
      S_IDLE, S_EXEC, S_DIV, S_EASE_A, S_EASE_B, S_EASE_C, S_EASE_D,
      S_MUL, S_SUM, S_OUT
   } state_type;

   typedef enum logic [1:0] {
      PATH_DONE, PATH_DIV, PATH_EASE
   } path_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic div_step;
      logic ease_a;
      logic ease_b;
      logic ease_c;
      logic ease_d;
      logic mul;
      logic sum;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      path_type path;
      logic     div_last;
   } ctrl_status_type;

   typedef logic signed [EASE_W-1:0] rom_type [ELASTIC_TABLE_DEPTH];

   // Out-elastic curve: 2^(-10x) * sin((10x - 0.75) / 3 turns) + 1, in Q16.
   function automatic rom_type build_elastic_rom();
      rom_type rom;
      longint x, t, f, y, term, ex, v, turns, r, a, a2, st, ss, e;
      longint n, q;
      for (int i = 0; i < ELASTIC_TABLE_DEPTH; i++) begin
         x = (longint'(i) * 64'sd65536) / ELASTIC_TABLE_DEPTH;
         t = 64'sd10 * x;
         n = (t >>> 16) & 64'sd31;
         f = t & 64'sd65535;
         y = (f * LN2_Q30) >>> 16;
         term = Q30_ONE;
         ex = Q30_ONE;
         term = -((term * y) / Q30_ONE);           ex = ex + term;
         term = -((term * y) / Q30_ONE) / 64'sd2;  ex = ex + term;
         term = -((term * y) / Q30_ONE) / 64'sd3;  ex = ex + term;
         term = -((term * y) / Q30_ONE) / 64'sd4;  ex = ex + term;
         term = -((term * y) / Q30_ONE) / 64'sd5;  ex = ex + term;
         term = -((term * y) / Q30_ONE) / 64'sd6;  ex = ex + term;
         term = -((term * y) / Q30_ONE) / 64'sd7;  ex = ex + term;
         term = -((term * y) / Q30_ONE) / 64'sd8;  ex = ex + term;
         term = -((term * y) / Q30_ONE) / 64'sd9;  ex = ex + term;
         term = -((term * y) / Q30_ONE) / 64'sd10; ex = ex + term;
         term = -((term * y) / Q30_ONE) / 64'sd11; ex = ex + term;
         term = -((term * y) / Q30_ONE) / 64'sd12; ex = ex + term;
         // The series value lies between one half and one, so the shift
         // matches a division that truncates toward zero.
         ex = ex >>> n;
         v = ((t - 64'sd49152) * 64'sd65536) / 64'sd3;
         turns = (v + 64'sd4294967296) & 64'sd4294967295;
         q = turns >>> 30;
         r = turns & 64'sd1073741823;
         if ((q & 64'sd1) != 0) begin
            r = Q30_ONE - r;
         end
         a = (r * HALF_PI_Q30) >>> 30;
         a2 = (a * a) / Q30_ONE;
         st = a;
         ss = a;
         st = -((st * a2) / Q30_ONE) / 64'sd6;   ss = ss + st;
         st = -((st * a2) / Q30_ONE) / 64'sd20;  ss = ss + st;
         st = -((st * a2) / Q30_ONE) / 64'sd42;  ss = ss + st;
         st = -((st * a2) / Q30_ONE) / 64'sd72;  ss = ss + st;
         st = -((st * a2) / Q30_ONE) / 64'sd110; ss = ss + st;
         st = -((st * a2) / Q30_ONE) / 64'sd156; ss = ss + st;
         st = -((st * a2) / Q30_ONE) / 64'sd210; ss = ss + st;
         if (q >= 2) begin
            ss = -ss;
         end
         e = (ex * ss) / Q30_ONE + Q30_ONE;
         rom[i] = EASE_W'(e / 64'sd16384);
      end
      rom[0] = '0;
      return rom;
   endfunction

   localparam rom_type ELASTIC_ROM = build_elastic_rom();

endpackage

>>> hw/rtl/etw_ctrl.sv
module etw_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  etw_pkg::ctrl_status_type status,
   output etw_pkg::ctrl_cmd_type    cmd
);
   import etw_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            case (status.path)
               PATH_DIV:  state_in = S_DIV;
               PATH_EASE: state_in = S_EASE_A;
               default:   state_in = S_OUT;
            endcase
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_EASE_A;
            end
         end
         S_EASE_A: begin
            cmd.ease_a = 1'b1;
            state_in = S_EASE_B;
         end
         S_EASE_B: begin
            cmd.ease_b = 1'b1;
            state_in = S_EASE_C;
         end
         S_EASE_C: begin
            cmd.ease_c = 1'b1;
            state_in = S_EASE_D;
         end
         S_EASE_D: begin
            cmd.ease_d = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul = 1'b1;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.sum = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

>>> hw/rtl/etw_datapath.sv
module etw_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [1:0]               csr_index,
   input  logic [31:0]              csr_wdata,
   input  logic [1:0]               req_cmd,
   input  logic [15:0]              req_delta_ticks,
   input  logic signed [31:0]       req_load_value,
   input  etw_pkg::ctrl_cmd_type    cmd,
   output etw_pkg::ctrl_status_type status,
   output logic signed [31:0]       rsp_value,
   output logic                     rsp_running
);
   import etw_pkg::*;

   logic signed [31:0] target_ff;
   logic [23:0]        duration_ff, delay_ff;
   logic [1:0]         mode_ff;

   logic [1:0]         cmd_ff;
   logic [15:0]        delta_ff;
   logic signed [31:0] load_ff;

   logic signed [31:0] current_ff, current_in;
   logic signed [31:0] start_ff, start_in;
   logic signed [25:0] elapsed_ff, elapsed_in;
   logic               active_ff, active_in;

   logic [16:0]        pct_ff;
   logic [23:0]        rem_ff;
   logic [DIV_CW-1:0]  cnt_ff;

   logic [33:0]        sq_ff;
   logic signed [EASE_W-1:0] rom_q_ff;
   logic [16:0]        x2_ff;
   logic [33:0]        cube_ff;
   logic signed [36:0] m3_ff, m1_ff;
   logic signed [EASE_W-1:0] eased_ff;
   logic signed [52:0] prod_ff;

   logic signed [31:0] rsp_value_ff;
   logic               rsp_running_ff;

   logic signed [26:0] e_sum, e_clamp;
   logic               tick_active;
   logic [24:0]        rem2;
   logic               qbit;
   logic [ROM_AW+16:0] addr_prod;
   logic [ROM_AW-1:0]  rom_addr;
   logic [16:0]        x2, x3;
   logic signed [36:0] back_diff, back_adj;
   logic signed [EASE_W-1:0] ease_sel;
   logic signed [32:0] span;
   logic signed [52:0] prod_adj;
   logic signed [36:0] step_q;
   logic signed [37:0] res;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         duration_ff <= '0;
         delay_ff <= '0;
         mode_ff <= EASE_LINEAR;
      end else if (csr_we) begin
         case (csr_index)
            REG_TARGET:   target_ff <= csr_wdata;
            REG_DURATION: duration_ff <= csr_wdata[23:0];
            REG_DELAY:    delay_ff <= csr_wdata[23:0];
            REG_EASING:   mode_ff <= csr_wdata[1:0];
            default:      ;
         endcase
      end
   end

   assign tick_active = (cmd_ff == CMD_TICK) && active_ff;
   assign e_sum = 27'(elapsed_ff) + $signed({11'd0, delta_ff});
   assign e_clamp = (e_sum > $signed({3'd0, duration_ff})) ?
                    $signed({3'd0, duration_ff}) : e_sum;

   always_comb begin
      if (!tick_active) begin
         status.path = PATH_DONE;
      end else if (e_clamp < 0 || e_clamp >= $signed({3'd0, duration_ff})) begin
         status.path = PATH_EASE;
      end else begin
         status.path = PATH_DIV;
      end
      status.div_last = (cnt_ff == DIV_CW'(DIV_STEPS - 1));
   end

   always_comb begin
      current_in = current_ff;
      start_in = start_ff;
      elapsed_in = elapsed_ff;
      active_in = active_ff;
      if (cmd.exec) begin
         case (cmd_ff)
            CMD_TICK: begin
               if (active_ff) begin
                  elapsed_in = e_clamp[25:0];
                  if (e_clamp >= $signed({3'd0, duration_ff})) begin
                     active_in = 1'b0;
                  end
               end
            end
            CMD_START: begin
               start_in = current_ff;
               elapsed_in = -$signed({2'd0, delay_ff});
               active_in = 1'b1;
            end
            CMD_CANCEL: begin
               active_in = 1'b0;
               start_in = '0;
               elapsed_in = '0;
            end
            CMD_LOAD: current_in = load_ff;
            default: ;
         endcase
      end
      if (cmd.sum) begin
         if (res > 38'sd2147483647) begin
            current_in = 32'sh7FFFFFFF;
         end else if (res < -38'sd2147483648) begin
            current_in = 32'sh80000000;
         end else begin
            current_in = res[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         current_ff <= '0;
         start_ff <= '0;
         elapsed_ff <= '0;
         active_ff <= 1'b0;
      end else begin
         current_ff <= current_in;
         start_ff <= start_in;
         elapsed_ff <= elapsed_in;
         active_ff <= active_in;
      end
   end

   assign rem2 = {rem_ff, 1'b0};
   assign qbit = (rem2 >= {1'b0, duration_ff});

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff <= req_cmd;
         delta_ff <= req_delta_ticks;
         load_ff <= req_load_value;
      end
      if (cmd.exec) begin
         cnt_ff <= '0;
         rem_ff <= e_clamp[23:0];
         if (e_clamp < 0) begin
            pct_ff <= '0;
         end else if (e_clamp >= $signed({3'd0, duration_ff})) begin
            pct_ff <= PCT_ONE;
         end else begin
            pct_ff <= '0;
         end
      end
      if (cmd.div_step) begin
         cnt_ff <= cnt_ff + 1'b1;
         rem_ff <= qbit ? 24'(rem2 - {1'b0, duration_ff}) : rem2[23:0];
         pct_ff <= {pct_ff[15:0], qbit};
      end
   end

   assign addr_prod = {{ROM_AW{1'b0}}, pct_ff} * (ROM_AW+17)'(ELASTIC_TABLE_DEPTH);
   assign rom_addr = addr_prod[16 +: ROM_AW];
   assign x2 = sq_ff[32:16];
   assign x3 = cube_ff[32:16];
   assign back_diff = m3_ff - m1_ff;
   assign back_adj = back_diff + ((back_diff < 0) ? 37'sd65535 : 37'sd0);

   always_comb begin
      case (mode_ff)
         EASE_ELASTIC: ease_sel = pct_ff[16] ? $signed({3'd0, PCT_ONE}) : rom_q_ff;
         EASE_BACK:    ease_sel = back_adj[16 +: EASE_W];
         default:      ease_sel = $signed({3'd0, pct_ff});
      endcase
   end

   assign span = 33'(target_ff) - 33'(start_ff);
   assign prod_adj = prod_ff + ((prod_ff < 0) ? 53'sd65535 : 53'sd0);
   assign step_q = prod_adj[52:16];
   assign res = 38'(start_ff) + 38'(step_q);

   always_ff @(posedge clock) begin
      if (cmd.ease_a) begin
         sq_ff <= {17'd0, pct_ff} * {17'd0, pct_ff};
         rom_q_ff <= ELASTIC_ROM[rom_addr];
      end
      if (cmd.ease_b) begin
         x2_ff <= x2;
         cube_ff <= {17'd0, x2} * {17'd0, pct_ff};
      end
      if (cmd.ease_c) begin
         m3_ff <= $signed({19'd0, BACK_C3} * {19'd0, x3});
         m1_ff <= $signed({19'd0, BACK_C1} * {19'd0, x2_ff});
      end
      if (cmd.ease_d) begin
         eased_ff <= ease_sel;
      end
      if (cmd.mul) begin
         prod_ff <= 53'(span) * 53'(eased_ff);
      end
      if (cmd.out_load) begin
         rsp_value_ff <= current_ff;
         rsp_running_ff <= active_ff;
      end
   end

   assign rsp_value = rsp_value_ff;
   assign rsp_running = rsp_running_ff;

endmodule

>>> hw/rtl/eased_tween_interpolator_core.sv
// Channel  Direction  Contents
// req      in         tuser: cmd; tdata: delta_ticks, load_value
// rsp      out        tdata: value, running
// csr      in         csr_we, csr_index, csr_wdata (write only)
// A tick that needs a division runs the 16-step serial divider for pct, then the
// easing and multiply chain. A tick in the delay phase or at the end skips the
// divider. Reset is synchronous; it clears the control, CSR and tween state,
// but not the request, divider, easing and output registers.
// A waiting result is held in the output register while the next beat is taken.
module eased_tween_interpolator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // delta_ticks[15:0], load_value[47:16]
   input  logic [1:0]  req_tuser,  // cmd[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // value[31:0], running[32], zero fill
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import etw_pkg::*;

   ctrl_cmd_type       cmd;
   ctrl_status_type    status;
   logic signed [31:0] value;
   logic               running;

   etw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   etw_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_cmd         (req_tuser),
      .req_delta_ticks (req_tdata[15:0]),
      .req_load_value  (req_tdata[47:16]),
      .cmd             (cmd),
      .status          (status),
      .rsp_value       (value),
      .rsp_running     (running)
   );

   assign rsp_tdata = {7'd0, running, value};

endmodule
